// ===== design/hrp_pkg.sv =====
// Shared types and constants of the HEX record parser.
// Used by hrp_core and hex_record_parser; depends on nothing.
`default_nettype none

package hrp_pkg;

	// Most data bytes per record emitted as data transfers; longer bodies are flagged too long.
	localparam logic [7:0] MAX_DATA = 8'd16;

	// Record type codes.
	localparam logic [7:0] REC_DATA = 8'h00;
	localparam logic [7:0] REC_EOF  = 8'h01;
	localparam logic [7:0] REC_ESA  = 8'h02;
	localparam logic [7:0] REC_SSA  = 8'h03;
	localparam logic [7:0] REC_ELA  = 8'h04;
	localparam logic [7:0] REC_SLA  = 8'h05;

	// Summary status codes.
	localparam logic [2:0] STATUS_OK       = 3'd0;
	localparam logic [2:0] STATUS_BAD_SUM  = 3'd1;
	localparam logic [2:0] STATUS_OBSOLETE = 3'd2;
	localparam logic [2:0] STATUS_UNKNOWN  = 3'd3;
	localparam logic [2:0] STATUS_TOO_LONG = 3'd4;

	// Width of the packed result payload on the master side.
	localparam int unsigned RES_DATA_W = 88;

	typedef struct packed {
		logic        result_kind;
		logic [7:0]  data_value;
		logic [3:0]  data_index;
		logic [15:0] load_address;
		logic [15:0] upper_address;
		logic [7:0]  record_kind;
		logic [2:0]  status;
		logic [31:0] start_address;
		logic        end_of_file;
		logic        last;
	} result_t;

endpackage

`default_nettype wire

// ===== design/hrp_core.sv =====
// Record parsing state and the per-byte logic of the HEX record parser.
// Depends on hrp_pkg for record codes, status codes and result_t.
`default_nettype none

module hrp_core #(
	parameter logic [7:0] MAX_DATA = hrp_pkg::MAX_DATA
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic [7:0]      rec_byte,
	input  wire logic            rec_start,
	input  wire logic            transfer_complete,
	output hrp_pkg::result_t     res,
	output logic                 res_valid
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADDR_HI,
		ST_ADDR_LO,
		ST_TYPE,
		ST_BODY
	} pos_t;

	pos_t        pos_q,   pos_n;
	logic [7:0]  count_q, count_n;
	logic [15:0] addr_q,  addr_n;
	logic [7:0]  type_q,  type_n;
	logic [7:0]  sum_q,   sum_n;
	logic [15:0] upper_q, upper_n;
	logic [31:0] start_q, start_n;
	logic [31:0] cap_q,   cap_n;
	logic [7:0]  seen_q,  seen_n;
	logic [7:0]  sum_all;

	assign sum_all = sum_q + rec_byte;

	always_comb begin
		pos_n   = pos_q;
		count_n = count_q;
		addr_n  = addr_q;
		type_n  = type_q;
		sum_n   = sum_q;
		upper_n = upper_q;
		start_n = start_q;
		cap_n   = cap_q;
		seen_n  = seen_q;

		res_valid         = 1'b0;
		res.result_kind   = 1'b0;
		res.data_value    = 8'h00;
		res.data_index    = 4'h0;
		res.load_address  = addr_q;
		res.upper_address = upper_q;
		res.record_kind   = type_q;
		res.status        = hrp_pkg::STATUS_OK;
		res.start_address = start_q;
		res.end_of_file   = 1'b0;
		res.last          = 1'b0;

		if (transfer_complete) begin
			if (rec_start) begin
				count_n = rec_byte;
				sum_n   = rec_byte;
				addr_n  = 16'h0000;
				type_n  = 8'h00;
				cap_n   = 32'h0000_0000;
				seen_n  = 8'h00;
				pos_n   = ST_ADDR_HI;
			end else begin
				unique case (pos_q)
					ST_ADDR_HI: begin
						addr_n = {rec_byte, 8'h00};
						sum_n  = sum_all;
						pos_n  = ST_ADDR_LO;
					end
					ST_ADDR_LO: begin
						addr_n = {addr_q[15:8], rec_byte};
						sum_n  = sum_all;
						pos_n  = ST_TYPE;
					end
					ST_TYPE: begin
						type_n = rec_byte;
						sum_n  = sum_all;
						pos_n  = ST_BODY;
					end
					ST_BODY: begin
						if (seen_q < count_q) begin
							sum_n  = sum_all;
							seen_n = seen_q + 8'd1;
							// The first four data bytes are kept big-endian for
							// the extended linear and start linear address records.
							if (seen_q[7:2] == 6'd0) begin
								unique case (seen_q[1:0])
									2'd0: cap_n[31:24] = rec_byte;
									2'd1: cap_n[23:16] = rec_byte;
									2'd2: cap_n[15:8]  = rec_byte;
									2'd3: cap_n[7:0]   = rec_byte;
									default: ;
								endcase
							end
							if (type_q == hrp_pkg::REC_DATA && seen_q < MAX_DATA) begin
								res_valid        = 1'b1;
								res.data_value   = rec_byte;
								res.data_index   = seen_q[3:0];
								res.load_address = addr_q + {8'h00, seen_q};
							end
						end else begin
							// Checksum byte: address updates apply even when the
							// checksum fails.
							if (type_q == hrp_pkg::REC_ELA) begin
								upper_n = cap_q[31:16];
							end else if (type_q == hrp_pkg::REC_SLA) begin
								start_n = cap_q;
							end
							res_valid         = 1'b1;
							res.result_kind   = 1'b1;
							res.upper_address = upper_n;
							res.start_address = start_n;
							res.end_of_file   = (type_q == hrp_pkg::REC_EOF);
							res.last          = 1'b1;
							priority if (sum_all != 8'h00) begin
								res.status = hrp_pkg::STATUS_BAD_SUM;
							end else if (count_q > MAX_DATA) begin
								res.status = hrp_pkg::STATUS_TOO_LONG;
							end else if (type_q > hrp_pkg::REC_SLA) begin
								res.status = hrp_pkg::STATUS_UNKNOWN;
							end else if (type_q == hrp_pkg::REC_ESA ||
									type_q == hrp_pkg::REC_SSA) begin
								res.status = hrp_pkg::STATUS_OBSOLETE;
							end else begin
								res.status = hrp_pkg::STATUS_OK;
							end
							pos_n = ST_IDLE;
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= ST_IDLE;
			count_q <= 8'h00;
			addr_q  <= 16'h0000;
			type_q  <= 8'h00;
			sum_q   <= 8'h00;
			upper_q <= 16'h0000;
			start_q <= 32'h0000_0000;
			cap_q   <= 32'h0000_0000;
			seen_q  <= 8'h00;
		end else if (en) begin
			pos_q   <= pos_n;
			count_q <= count_n;
			addr_q  <= addr_n;
			type_q  <= type_n;
			sum_q   <= sum_n;
			upper_q <= upper_n;
			start_q <= start_n;
			cap_q   <= cap_n;
			seen_q  <= seen_n;
		end
	end

	// A result is only produced from the body state.
	a_res_in_body: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> pos_q == ST_BODY)
		else $error("result produced outside the record body");

	// A summary always returns the parser to idle.
	a_sum_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(en && res_valid && res.last) |=> pos_q == ST_IDLE)
		else $error("parser not idle after a summary");

	// The body counter never runs past the count byte.
	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q == ST_BODY |-> seen_q <= count_q)
		else $error("body counter past record count");

endmodule

`default_nettype wire

// ===== design/hex_record_parser.sv =====
// Top level of the HEX record parser: input register, parsing core and result register.
// Depends on hrp_pkg and hrp_core.
//
//   Channel  Direction  Signals                      Content
//   s_*      in         tvalid tready tdata tuser    one record byte and its flags
//   m_*      out        tvalid tready tdata tuser    one data byte or a record summary
//                       tlast
//
// A byte is first held in the input register, then passes through the parsing logic
// into the result register. One byte is taken every cycle while the master side keeps
// m_tready high. When a result waits in the result register and m_tready is low, the
// input register holds its byte and s_tready falls once it is full. Reset (arst_n
// low) empties both registers and clears all parsing state, including the upper and
// start addresses.
`default_nettype none

module hex_record_parser #(
	parameter logic [7:0] MAX_DATA = hrp_pkg::MAX_DATA
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	input  wire logic [7:0]                           s_tdata,  // rec_byte
	input  wire logic [1:0]                           s_tuser,  // rec_start, transfer_complete
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	// data_value, data_index, load_address, upper_address, record_kind, status,
	// start_address, end_of_file
	output logic [hrp_pkg::RES_DATA_W-1:0]            m_tdata,
	output logic                                      m_tuser,  // result_kind
	output logic                                      m_tlast   // last
);

	logic              vld_s1;
	logic [7:0]        byte_s1;
	logic              start_s1;
	logic              done_s1;
	logic              vld_s2;
	hrp_pkg::result_t  res_s2;
	hrp_pkg::result_t  res;
	logic              res_valid;
	logic              adv;

	// The byte in the input register is processed when the result register is free
	// or is being emptied in this cycle.
	assign adv      = vld_s1 && (!vld_s2 || m_tready);
	assign s_tready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1  <= s_tdata;
			start_s1 <= s_tuser[0];
			done_s1  <= s_tuser[1];
		end
	end

	hrp_core #(
		.MAX_DATA (MAX_DATA)
	) u_core (
		.clk               (clk),
		.arst_n            (arst_n),
		.en                (adv),
		.rec_byte          (byte_s1),
		.rec_start         (start_s1),
		.transfer_complete (done_s1),
		.res               (res),
		.res_valid         (res_valid)
	);

	// Result register. A byte that yields no result simply leaves it empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= res_valid;
		end else if (m_tready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tuser  = res_s2.result_kind;
	assign m_tlast  = res_s2.last;
	assign m_tdata  = {res_s2.end_of_file, res_s2.start_address, res_s2.status,
			res_s2.record_kind, res_s2.upper_address, res_s2.load_address,
			res_s2.data_index, res_s2.data_value};

	// Only summaries end a record, and every summary does.
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tlast == m_tuser)
		else $error("tlast and result kind disagree");

	// Data transfers always carry an ok status.
	a_data_status: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> m_tdata[54:52] == hrp_pkg::STATUS_OK)
		else $error("data transfer with non-zero status");

	// A waiting result is never overwritten by a byte behind it.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && !m_tready) |-> !adv)
		else $error("result register overwritten while stalled");

endmodule

`default_nettype wire
